@@ hdl/s2lab_pkg.sv @@
// shared constants, types and the linearization table builder for the srgb to cielab block
`timescale 1ns / 1ps

package s2lab_pkg;

  typedef logic [30:0] lin_tab_t [256];

  // srgb to xyz matrix, q20
  localparam logic [19:0] MAT_Q20 [3][3] = '{
    '{20'd432492, 20'd374946, 20'd189202},
    '{20'd223004, 20'd749891, 20'd75681},
    '{20'd20273,  20'd124982, 20'd996466}
  };

  localparam logic [19:0] WHITE_X = 20'd996625;
  localparam logic [20:0] WHITE_Z = 21'd1141641;

  // reciprocals for the white point divide, scaled by 2^51
  localparam logic [31:0] RECIP_X = 32'((64'd1 << 51) / 64'd996625);
  localparam logic [31:0] RECIP_Z = 32'((64'd1 << 51) / 64'd1141641);

  localparam logic [30:0] EPS_Q30 = 31'd9509058;

  // linear segment of f: (9033 t + 160 * 2^30) / 1160 split as LIN_A + (9033 t + LIN_B) / 1160
  localparam logic [27:0] LIN_A = 28'((64'd160 << 30) / 64'd1160);
  localparam logic [9:0]  LIN_B = 10'((64'd160 << 30) % 64'd1160);
  localparam logic [13:0] LIN_K = 14'd9033;
  localparam logic [7:0]  DIV_145 = 8'd145;
  localparam logic [26:0] RECIP_145 = 27'((64'd1 << 34) / 64'd145);

  function automatic logic [30:0] lin_q30(input int unsigned c);
    logic [63:0] tq;
    logic [63:0] u;
    logic [63:0] r;
    logic [63:0] cand;
    logic [63:0] y2;
    logic [63:0] y4;
    logic [63:0] p5;
    r = '0;
    if (c <= 10) begin
      return 31'((64'(c) * 64'd100 * (64'd1 << 30)) / 64'd329460);
    end
    tq = ((64'd1000 * 64'(c) + 64'd14025) << 30) / 64'd269025;
    u = (tq * tq) >> 30;
    for (int b = 30; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      y2 = (cand * cand) >> 30;
      y4 = (y2 * y2) >> 30;
      p5 = (y4 * cand) >> 30;
      if (cand <= (64'd1 << 30) && p5 <= u) begin
        r = cand;
      end
    end
    return 31'((u * r) >> 30);
  endfunction

  function automatic lin_tab_t lin_table();
    lin_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = lin_q30(i);
    end
    return tab;
  endfunction

endpackage

@@ hdl/srgb_to_cielab.sv @@
// srgb_to_cielab: pipelined srgb (8 bit) to cielab d65 converter
// input beats carry one pixel on s_axis (red, green, blue codes in tdata).
// output beats carry L*, a*, b* on m_axis in fixed point with OUT_FRAC_BITS
// fraction bits; L* is saturated to 0..100, a* and b* to the 16 bit range.
// the pipeline from input beat to output beat holds: table lookup, matrix,
// white point divide (reciprocal multiply plus one correction), a 31 step
// bit-serial cube root with two stages per bit, the linear segment of f,
// and two stages that form L, a, b and round them.
// throughput is one pixel per clock; every stage is a register with a valid
// bit, so a new beat can enter each cycle.
// when m_axis_tready is low while a result is waiting the whole pipeline
// holds and s_axis_tready drops; bubbles inside never block input.
// rst clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps

module srgb_to_cielab import s2lab_pkg::*; #(
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red_in [7:0], green_in [15:8], blue_in [23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // lightness [14:0], green_red [30:15], blue_yellow [46:31]
);

  localparam int NSTG = 73;
  localparam int SHIFT = 30 - OUT_FRAC_BITS;
  localparam int LMAX_I = ((100 << OUT_FRAC_BITS) > 32767) ? 32767 : (100 << OUT_FRAC_BITS);
  localparam logic signed [41:0] LMAX = 42'(LMAX_I);
  localparam logic signed [41:0] CMAX = 42'sd32767;
  localparam logic signed [41:0] CMIN = -42'sd32768;
  localparam logic signed [41:0] HALF = 42'sd1 <<< (SHIFT - 1);
  localparam lin_tab_t LIN_TAB = lin_table();

  logic            en;
  logic [NSTG-1:0] vld;

  assign en = !vld[NSTG-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], s_axis_tvalid};
    end
  end

  // front: table, matrix, white point divide
  logic [30:0] lin0 [3];
  logic [50:0] prod [3][3];
  logic [30:0] xyz [3];
  logic [62:0] px3;
  logic [62:0] pz3;
  logic [30:0] x3, y3, z3;
  logic [31:0] qx4, qz4;
  logic [51:0] qdx4, qdz4;
  logic [30:0] x4, y4, z4;
  logic [30:0] tin [3];
  logic [51:0] remx, remz;
  logic [31:0] qx5, qz5;

  always_comb begin
    remx = {1'b0, x4, 20'b0} - qdx4;
    remz = {1'b0, z4, 20'b0} - qdz4;
    qx5 = (remx >= 52'(WHITE_X)) ? qx4 + 32'd1 : qx4;
    qz5 = (remz >= 52'(WHITE_Z)) ? qz4 + 32'd1 : qz4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        lin0[i] <= LIN_TAB[s_axis_tdata[8*i +: 8]];
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= 51'(MAT_Q20[i][j]) * 51'(lin0[j]);
        end
        xyz[i] <= 31'((52'(prod[i][0]) + 52'(prod[i][1]) + 52'(prod[i][2])) >> 20);
      end
      px3 <= 63'(xyz[0]) * 63'(RECIP_X);
      pz3 <= 63'(xyz[2]) * 63'(RECIP_Z);
      x3 <= xyz[0];
      y3 <= xyz[1];
      z3 <= xyz[2];
      qx4 <= px3[62:31];
      qz4 <= pz3[62:31];
      qdx4 <= 52'(px3[62:31]) * 52'(WHITE_X);
      qdz4 <= 52'(pz3[62:31]) * 52'(WHITE_Z);
      x4 <= x3;
      y4 <= y3;
      z4 <= z3;
      tin[0] <= qx5[31] ? 31'h7fffffff : qx5[30:0];
      tin[1] <= y4;
      tin[2] <= qz5[31] ? 31'h7fffffff : qz5[30:0];
    end
  end

  // bit-serial cube root, two stages per bit: square, then cube and compare
  logic [30:0] r_in [3][31];
  logic [30:0] t_in [3][31];
  logic [30:0] ra [3][31];
  logic [30:0] ca [3][31];
  logic [31:0] sqa [3][31];
  logic [30:0] ta [3][31];
  logic [30:0] rb [3][31];
  logic [30:0] tb [3][31];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    for (genvar k = 0; k < 31; k++) begin : g_bit
      logic [30:0] cand;
      logic [63:0] cube;
      if (k == 0) begin : g_first
        assign r_in[c][k] = '0;
        assign t_in[c][k] = tin[c];
      end else begin : g_next
        assign r_in[c][k] = rb[c][k-1];
        assign t_in[c][k] = tb[c][k-1];
      end
      assign cand = r_in[c][k] | (31'd1 << (30 - k));
      assign cube = (64'(sqa[c][k]) * 64'(ca[c][k])) >> 30;
      always_ff @(posedge clk) begin
        if (en) begin
          ra[c][k]  <= r_in[c][k];
          ca[c][k]  <= cand;
          sqa[c][k] <= 32'((64'(cand) * 64'(cand)) >> 30);
          ta[c][k]  <= t_in[c][k];
          rb[c][k]  <= (cube <= 64'(ta[c][k])) ? ca[c][k] : ra[c][k];
          tb[c][k]  <= ta[c][k];
        end
      end
    end
  end

  // linear segment of f and branch select
  logic [30:0] fr1 [3];
  logic [30:0] fr2 [3];
  logic        br1 [3];
  logic        br2 [3];
  logic [36:0] n1 [3];
  logic [61:0] p2 [3];
  logic [33:0] m2 [3];
  logic [30:0] f3 [3];
  logic [27:0] q3 [3];
  logic [27:0] qa3 [3];
  logic [33:0] rem3 [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q3[c] = p2[c][61:34];
      rem3[c] = m2[c] - 34'(q3[c]) * 34'(DIV_145);
      qa3[c] = (rem3[c] >= 34'(DIV_145)) ? q3[c] + 28'd1 : q3[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        fr1[c] <= rb[c][30];
        br1[c] <= tb[c][30] > EPS_Q30;
        n1[c]  <= 37'(LIN_K) * 37'(tb[c][30][23:0]) + 37'(LIN_B);
        fr2[c] <= fr1[c];
        br2[c] <= br1[c];
        m2[c]  <= n1[c][36:3];
        p2[c]  <= 62'(n1[c][36:3]) * 62'(RECIP_145);
        f3[c]  <= br2[c] ? fr2[c] : 31'(LIN_A + qa3[c]);
      end
    end
  end

  // L, a, b and rounding
  logic signed [41:0] lv, av, bv;
  logic signed [41:0] lq, aq, bq;
  logic [14:0] lo;
  logic [15:0] ao, bo;

  always_comb begin
    lq = (lv + HALF) >>> SHIFT;
    aq = (av + HALF) >>> SHIFT;
    bq = (bv + HALF) >>> SHIFT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lv <= $signed(42'(f3[1])) * 42'sd116 - (42'sd1 <<< 34);
      av <= ($signed(42'(f3[0])) - $signed(42'(f3[1]))) * 42'sd500;
      bv <= ($signed(42'(f3[1])) - $signed(42'(f3[2]))) * 42'sd200;
      lo <= (lq < 0) ? 15'd0 : (lq > LMAX) ? LMAX[14:0] : lq[14:0];
      ao <= (aq < CMIN) ? CMIN[15:0] : (aq > CMAX) ? CMAX[15:0] : aq[15:0];
      bo <= (bq < CMIN) ? CMIN[15:0] : (bq > CMAX) ? CMAX[15:0] : bq[15:0];
    end
  end

  assign m_axis_tdata = {1'b0, bo, ao, lo};

endmodule
